// File: design/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants for the 3D vector normalizer: output and quotient widths,
// unit scale and the width of the minimum-length register.
// ----------------------------------------------------------------------------
package vn_pkg;

  // Result components are signed Q1.14 in 16 bits
  localparam int OUT_W     = 16;
  localparam int UNIT_FRAC = 14;
  // Quotient magnitude reaches 2**UNIT_FRAC, so it needs one more bit
  localparam int Q_W       = UNIT_FRAC + 1;
  // Minimum-length register width
  localparam int CFG_W     = 16;

endpackage

// File: design/vn_isqrt.sv
// ----------------------------------------------------------------------------
// vn_isqrt
// Pipelined floor square root, one root bit per stage (W stages), with a
// side payload that travels alongside each item.
// ----------------------------------------------------------------------------
module vn_isqrt #(
  parameter int W  = 16,
  parameter int PW = 51
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*W-1:0]  sum_i,
  input  logic [PW-1:0]   pay_i,
  output logic [W-1:0]    root_o,
  output logic [PW-1:0]   pay_o
);

  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rest_q [W];
  logic [PW-1:0]  pay_q  [W];

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic [W+1:0]   rem_p;
    logic [W-1:0]   root_p;
    logic [2*W-1:0] rest_p;
    logic [PW-1:0]  pay_p;
    logic [W+3:0]   cur;
    logic [W+3:0]   trial;
    logic           ge;

    // previous stage, or the fresh operand at the first stage
    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = sum_i;
      assign pay_p  = pay_i;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign rest_p = rest_q[j-1];
      assign pay_p  = pay_q[j-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      cur   = {rem_p, rest_p[2*W-1:2*W-2]};
      trial = (W+4)'({root_p, 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (W+2)'(cur - trial) : cur[W+1:0];
        root_q[j] <= {root_p[W-2:0], ge};
        rest_q[j] <= {rest_p[2*W-3:0], 2'b00};
        pay_q[j]  <= pay_p;
      end
    end
  end

  assign root_o = root_q[W-1];
  assign pay_o  = pay_q[W-1];

endmodule

// File: design/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div
// Three-lane pipelined restoring divider: q = mag * 2**14 / den, one quotient
// bit per stage. Relies on mag <= den, which holds for a vector length.
// ----------------------------------------------------------------------------
module vn_div
  import vn_pkg::*;
#(
  parameter int W = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   mag_i [3],
  input  logic [W-1:0]   den_i,
  input  logic [2:0]     neg_i,
  output logic [Q_W-1:0] q_o [3],
  output logic [W-1:0]   den_o,
  output logic [2:0]     neg_o
);

  logic [W-1:0]   rem_q [Q_W][3];
  logic [Q_W-1:0] q_q   [Q_W][3];
  logic [W-1:0]   den_q [Q_W];
  logic [2:0]     neg_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [W-1:0] den_p;
    logic [2:0]   neg_p;

    if (j == 0) begin : g_first
      assign den_p = den_i;
      assign neg_p = neg_i;
    end else begin : g_next
      assign den_p = den_q[j-1];
      assign neg_p = neg_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_p;
        neg_q[j] <= neg_p;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [W:0]     cur;
      logic           ge;
      logic [Q_W-1:0] q_n;

      // first stage compares mag itself, later ones the doubled remainder
      if (j == 0) begin : g_first
        assign cur = {1'b0, mag_i[l]};
        assign q_n = Q_W'(ge);
      end else begin : g_next
        assign cur = {rem_q[j-1][l], 1'b0};
        assign q_n = {q_q[j-1][l][Q_W-2:0], ge};
      end

      assign ge = (cur >= {1'b0, den_p});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j][l] <= ge ? W'(cur - {1'b0, den_p}) : cur[W-1:0];
          q_q[j][l]   <= q_n;
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign q_o[l] = q_q[Q_W-1][l];
  end
  assign den_o = den_q[Q_W-1];
  assign neg_o = neg_q[Q_W-1];

endmodule

// File: design/vector3_normalize.sv
// Throughput: one item per cycle; the pipeline (magnitude, square, sum,
//   one root bit per stage, one quotient bit per stage) holds only while its
//   last stage and the output register are both full and the output is not taken.
// Reset: rst_ni clears valid bits and min_length (to 0); payload is not reset.
// ----------------------------------------------------------------------------
// vector3_normalize
// Normalizes a 3D fixed-point vector to Q1.14 unit components and reports
// its length, flagging vectors whose length is at or below min_length.
// ----------------------------------------------------------------------------
module vector3_normalize
  import vn_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [CFG_W-1:0]                  cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_z_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [OUT_W-1:0]           unit_x_o,
  output logic signed [OUT_W-1:0]           unit_y_o,
  output logic signed [OUT_W-1:0]           unit_z_o,
  output logic [OUT_W-1:0]                  vec_length_o,
  output logic                              degenerate_o
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int NV  = 3 + W + Q_W;
  localparam int PW  = 3 * W + 3;
  localparam int LCW = (W > CFG_W) ? W : CFG_W;

  logic [CFG_W-1:0] min_length_q;
  logic [NV-1:0]    v_q;
  logic             out_valid_q;
  logic             en;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= '0;
    end else if (cfg_valid_i) begin
      min_length_q <= cfg_data_i;
    end
  end

  // pipeline advances unless the last stage and the output register are
  // both full and the output is not taken
  assign en         = !v_q[NV-1] || !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NV-2:0], in_valid_i};
    end
  end

  // stage 0: sign and magnitude
  logic [W-1:0] comp_in [3];
  logic [W-1:0] mag0_q  [3];
  logic [2:0]   neg0_q;
  assign comp_in[0] = comp_x_i;
  assign comp_in[1] = comp_y_i;
  assign comp_in[2] = comp_z_i;

  // stage 1: squares, stage 2: sum
  logic [2*W-1:0] sq1_q  [3];
  logic [W-1:0]   mag1_q [3];
  logic [2:0]     neg1_q;
  logic [2*W-1:0] sum2_q;
  logic [W-1:0]   mag2_q [3];
  logic [2:0]     neg2_q;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg0_q[i] <= comp_in[i][W-1];
        mag0_q[i] <= comp_in[i][W-1] ? W'(-comp_in[i]) : comp_in[i];
        sq1_q[i]  <= mag0_q[i] * mag0_q[i];
        mag1_q[i] <= mag0_q[i];
        neg1_q[i] <= neg0_q[i];
        mag2_q[i] <= mag1_q[i];
        neg2_q[i] <= neg1_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum2_q <= sq1_q[0] + sq1_q[1] + sq1_q[2];
    end
  end

  // square root with magnitudes and signs riding along
  logic [W-1:0]  root;
  logic [PW-1:0] sq_pay;
  logic [W-1:0]  div_mag [3];

  vn_isqrt #(
    .W  (W),
    .PW (PW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum2_q),
    .pay_i  ({neg2_q, mag2_q[2], mag2_q[1], mag2_q[0]}),
    .root_o (root),
    .pay_o  (sq_pay)
  );

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign div_mag[i] = sq_pay[i*W +: W];
  end

  // scale by 2**14 and divide by the length
  logic [Q_W-1:0] q   [3];
  logic [W-1:0]   len;
  logic [2:0]     neg;

  vn_div #(
    .W (W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (div_mag),
    .den_i (root),
    .neg_i (sq_pay[PW-1 -: 3]),
    .q_o   (q),
    .den_o (len),
    .neg_o (neg)
  );

  // output register: degenerate test and sign restore
  logic                    deg;
  logic signed [OUT_W-1:0] unit_q [3];
  logic [OUT_W-1:0]        len_q;
  logic                    deg_q;
  logic                    out_load;

  assign deg      = !(LCW'(len) > LCW'(min_length_q));
  assign out_load = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= v_q[NV-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unit
    always_ff @(posedge clk_i) begin
      if (out_load) begin
        if (deg) begin
          unit_q[i] <= '0;
        end else if (neg[i]) begin
          unit_q[i] <= -OUT_W'(q[i]);
        end else begin
          unit_q[i] <= OUT_W'(q[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      len_q <= deg ? '0 : OUT_W'(len);
      deg_q <= deg;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign unit_x_o     = unit_q[0];
  assign unit_y_o     = unit_q[1];
  assign unit_z_o     = unit_q[2];
  assign vec_length_o = len_q;
  assign degenerate_o = deg_q;

endmodule

// File: design/vn_checker.sv
// ----------------------------------------------------------------------------
// vn_assert
// Port-level checks for the vector normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module vn_assert
  import vn_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] unit_x_o,
  input logic signed [OUT_W-1:0] unit_y_o,
  input logic signed [OUT_W-1:0] unit_z_o,
  input logic [OUT_W-1:0]        vec_length_o,
  input logic                    degenerate_o
);

  // a stalled result holds its x component, length and degenerate flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(unit_x_o) &&
      $stable(vec_length_o) && $stable(degenerate_o))
    else $error("stalled result changed");

  // input is refused only under output backpressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without backpressure");

  // degenerate results are all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> unit_x_o == 0 && unit_y_o == 0 &&
      unit_z_o == 0 && vec_length_o == 0)
    else $error("degenerate result not zeroed");

  // unit components stay within one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> unit_x_o >= -16384 && unit_x_o <= 16384 &&
      unit_y_o >= -16384 && unit_y_o <= 16384 &&
      unit_z_o >= -16384 && unit_z_o <= 16384)
    else $error("unit component out of range");

endmodule

bind vector3_normalize vn_assert u_vn_assert (.*);
